// ----- rtl/bda_pkg.sv -----
package bda_pkg;

    // Fixed field widths
    localparam int LEVEL_BITS = 5;
    localparam int COUNT_W    = 5;
    localparam int TDATA_W    = 8;

    // Defaults
    localparam int              NUM_BUTTONS_DEFAULT = 5;
    localparam logic [COUNT_W-1:0] LIMIT_RESET      = 5'd20;

    // Counter codes with a fixed meaning
    localparam logic [COUNT_W-1:0] CNT_RELEASED = 5'd0;
    localparam logic [COUNT_W-1:0] CNT_FIRST    = 5'd1;
    localparam logic [COUNT_W-1:0] CNT_HELD     = 5'd2;

    // Per-button control from the top level
    typedef struct packed {
        logic step;     // an item is accepted this cycle
        logic pressed;  // button level is low on this item
    } bda_cell_ctl_t;

endpackage

// ----- rtl/bda_button.sv -----
module bda_button (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bda_pkg::bda_cell_ctl_t        ctl,
    input  logic [bda_pkg::COUNT_W-1:0]   repeat_limit,
    output logic                          fire
);
    import bda_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W:0]   count_inc;

    // One bit wider so a counter of 31 still exceeds any limit
    assign count_inc = {1'b0, count_reg} + {{COUNT_W{1'b0}}, 1'b1};

    // Hold counter next value and event
    always_comb begin
        fire       = 1'b0;
        count_next = count_reg;
        priority if (!ctl.pressed) begin
            count_next = CNT_RELEASED;
        end else if (count_reg == CNT_RELEASED) begin
            count_next = CNT_FIRST;
        end else if (count_reg == CNT_FIRST) begin
            fire       = 1'b1;
            count_next = CNT_HELD;
        end else if (count_inc > {1'b0, repeat_limit}) begin
            fire       = 1'b1;
            count_next = CNT_HELD;
        end else begin
            count_next = count_inc[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_RELEASED;
        end else if (ctl.step) begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/bda_out_stage.sv -----
module bda_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [bda_pkg::LEVEL_BITS-1:0] events_in,
    output logic                           load_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bda_pkg::TDATA_W-1:0]    m_tdata
);
    import bda_pkg::*;

    logic                  valid_reg;
    logic [LEVEL_BITS-1:0] events_reg;

    // Room when empty or the held item leaves this cycle
    assign load_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) begin
            events_reg <= events_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_W-LEVEL_BITS){1'b0}}, events_reg};

endmodule

// ----- rtl/button_debounce_autorepeat.sv -----
// Debounced button scanner with auto-repeat. Each item on the slave side is one
// timer tick with the sampled active-low levels of up to five buttons; each item
// on the master side is the mask of buttons firing a press or repeat event on that
// tick, one result per tick in order. A button fires on its second consecutive
// pressed tick, then again each time its hold counter exceeds repeat_limit
// (written on cfg_wr_en, reset 20). Throughput is one item per cycle while the
// master side keeps taking results: the hold counters update in parallel on
// acceptance and the mask lands in a single output register that can be refilled
// in the cycle it is taken. Buttons with index five or more have no level bit and never fire.
module button_debounce_autorepeat #(
    parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave tdata: [4:0] button_levels, [7:5] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bda_pkg::TDATA_W-1:0]    s_tdata,
    // master tdata: [4:0] press_events, [7:5] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bda_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [bda_pkg::COUNT_W-1:0]    cfg_wr_data
);
    import bda_pkg::*;

    // Only buttons that have a level bit need a counter
    localparam int NUM_ACTIVE = (NUM_BUTTONS < LEVEL_BITS) ? NUM_BUTTONS : LEVEL_BITS;

    logic [COUNT_W-1:0]    limit_reg;
    logic                  step;
    logic [LEVEL_BITS-1:0] levels;
    logic [LEVEL_BITS-1:0] fire_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    assign step   = s_tvalid && s_tready;
    assign levels = s_tdata[LEVEL_BITS-1:0];

    // Per-button counters
    for (genvar k = 0; k < NUM_ACTIVE; k++) begin : g_btn
        bda_cell_ctl_t ctl;
        assign ctl.step    = step;
        assign ctl.pressed = !levels[k];
        bda_button u_btn (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .repeat_limit (limit_reg),
            .fire         (fire_mask[k])
        );
    end

    for (genvar k = NUM_ACTIVE; k < LEVEL_BITS; k++) begin : g_none
        assign fire_mask[k] = 1'b0;
    end

    bda_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .events_in  (fire_mask),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");

    a_fire_only_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=>
            ((m_tdata[LEVEL_BITS-1:0] & $past(s_tdata[LEVEL_BITS-1:0])) == '0))
        else $error("event on a released button");
`endif

endmodule

// ----- bench/press_event_checker.sv -----
// Watches both item channels of the button scanner, predicts the event mask of every
// accepted tick and compares it with the master-side items in order.
module press_event_checker
    import bda_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    output int                 fail_count,
    output int                 pending,
    output int                 tick_count,
    output int                 repeat_count,
    output int                 wrap_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor state: one hold counter per button plus the repeat limit
    logic [COUNT_W-1:0]    hold_cnt [NUM_BUTTONS];
    logic [COUNT_W-1:0]    limit_reg;
    logic [LEVEL_BITS-1:0] expected_masks [$];
    int                    errs = 0;
    int                    n_ticks = 0;
    int                    n_repeats = 0;
    int                    n_wraps = 0;

    // advance every hold counter by one tick, return the mask of buttons firing
    function automatic logic [LEVEL_BITS-1:0] tick_events(input logic [LEVEL_BITS-1:0] levels);
        logic [LEVEL_BITS-1:0] fired;
        logic [COUNT_W:0]      bumped;
        bit                    pressed;
        fired = '0;
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            // buttons past the level bits have no pin and read as released
            pressed = (k < LEVEL_BITS) && !levels[k];
            if (!pressed) begin
                hold_cnt[k] = CNT_RELEASED;
            end else if (hold_cnt[k] == CNT_RELEASED) begin
                hold_cnt[k] = CNT_FIRST;
            end else if (hold_cnt[k] == CNT_FIRST) begin
                fired[k]    = 1'b1;
                hold_cnt[k] = CNT_HELD;
            end else begin
                // one bit wider, so a counter at 31 still reaches 32 and fires
                bumped = {1'b0, hold_cnt[k]} + {{COUNT_W{1'b0}}, 1'b1};
                if (bumped > {1'b0, limit_reg}) begin
                    fired[k]    = 1'b1;
                    hold_cnt[k] = CNT_HELD;
                    n_repeats++;
                    if (bumped[COUNT_W])
                        n_wraps++;
                end else begin
                    hold_cnt[k] = bumped[COUNT_W-1:0];
                end
            end
        end
        return fired;
    endfunction

    // results are checked before the tick of the same edge is predicted
    always @(posedge aclk) begin : track
        logic [LEVEL_BITS-1:0] want;
        logic [LEVEL_BITS-1:0] got;
        if (!aresetn) begin
            for (int k = 0; k < NUM_BUTTONS; k++)
                hold_cnt[k] = CNT_RELEASED;
            limit_reg = LIMIT_RESET;
            expected_masks.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[LEVEL_BITS-1:0];
                if (expected_masks.size() == 0) begin
                    errs++;
                    $display("%0t: press_events got %b with no tick outstanding", $time, got);
                end else begin
                    want = expected_masks.pop_front();
                    if (got !== want) begin
                        errs++;
                        $display("%0t: press_events expected %b got %b", $time, want, got);
                    end
                    if (m_tdata[TDATA_W-1:LEVEL_BITS] !== '0) begin
                        errs++;
                        $display("%0t: tdata padding expected 0 got %b",
                                 $time, m_tdata[TDATA_W-1:LEVEL_BITS]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_masks.push_back(tick_events(s_tdata[LEVEL_BITS-1:0]));
                n_ticks++;
            end
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
        end
        // published with nonblocking updates so the stimulus side reads settled values
        pending      <= expected_masks.size();
        fail_count   <= errs;
        tick_count   <= n_ticks;
        repeat_count <= n_repeats;
        wrap_count   <= n_wraps;
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bda_pkg::*;

    localparam int MAX_GAP          = 17;
    localparam int DRAIN_CYCLES     = 4;
    localparam int TICKS_PER_PHASE  = 85;
    localparam int NUM_PHASES       = 9;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;       // [4:0] button_levels, [7:5] zero
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;            // [4:0] press_events, [7:5] zero
    logic               cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;

    int chk_fails;
    int chk_pending;
    int chk_ticks;
    int chk_repeats;
    int chk_wraps;
    int quiet_cycles = 0;
    bit calm = 1'b0;                        // stretch with no idling on either side

    always #2 aclk = ~aclk;

    button_debounce_autorepeat DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    press_event_checker events_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (chk_fails),
        .pending      (chk_pending),
        .tick_count   (chk_ticks),
        .repeat_count (chk_repeats),
        .wrap_count   (chk_wraps)
    );

    // watchdog: cycles in which no item moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall before taking each item
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one timer tick, after a random gap; returns at the edge it is taken
    task automatic send_tick(input logic [LEVEL_BITS-1:0] levels);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-LEVEL_BITS){1'b0}}, levels};
        do @(posedge aclk); while (!s_tready);
    endtask

    // limit changes only once every tick has produced its mask
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // held buttons with random run lengths scaled to the limit, plus noise ticks
    task automatic random_phase(input logic [COUNT_W-1:0] limit, input int count);
        logic [LEVEL_BITS-1:0] lv;
        int                    span;
        lv   = '1;
        span = int'(limit) + 8;
        repeat (count) begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            if ($urandom_range(0, 9) == 0) begin
                send_tick(LEVEL_BITS'($urandom));
            end else begin
                for (int k = 0; k < LEVEL_BITS; k++)
                    if ($urandom_range(0, span) == 0)
                        lv[k] = ~lv[k];
                send_tick(lv);
            end
        end
    endtask

    initial begin : stimulus
        logic [COUNT_W-1:0] phase_limits [NUM_PHASES];
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit: all released, all pressed through the press, single buttons, patterns
        send_tick(5'h1F); send_tick(5'h00); send_tick(5'h00); send_tick(5'h00);
        send_tick(5'h1E); send_tick(5'h1D); send_tick(5'h1B); send_tick(5'h17);
        send_tick(5'h0F); send_tick(5'h1F);
        send_tick(5'h15); send_tick(5'h15); send_tick(5'h0A); send_tick(5'h0A);

        // smallest sensible limit: repeat every other tick after the press
        write_limit(5'd3);
        repeat (6) send_tick(5'h00);

        // limit below 3: a repeat on every held tick
        write_limit(5'd0);
        repeat (3) send_tick(5'h00);

        // random phases, extremes first
        phase_limits = '{5'd31, 5'd30, 5'd0, 5'd3, 5'd1, 5'd2,
                         COUNT_W'($urandom), LIMIT_RESET, COUNT_W'($urandom)};
        foreach (phase_limits[i]) begin
            write_limit(phase_limits[i]);
            random_phase(phase_limits[i], TICKS_PER_PHASE);
        end
        calm = 1'b0;

        // drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d ticks checked under repeat limits 0, 1, 2, 3, 20, 30, 31 and random",
                 chk_ticks);
        $display("%0d auto-repeat events predicted, %0d from a counter wrapping past 31",
                 chk_repeats, chk_wraps);
        if (chk_fails == 0 && chk_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bda_pkg.sv
rtl/bda_button.sv
rtl/bda_out_stage.sv
rtl/button_debounce_autorepeat.sv
bench/press_event_checker.sv
bench/testbench.sv
